@@ src/hst_pkg.sv @@
// ----------------------------------------------------------------------------
// hst_pkg
// Types, state and event codes, and the per-character tokenizer step.
// ----------------------------------------------------------------------------
package hst_pkg;

  localparam int unsigned MaxEv = 6;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned MaxPasses = 5;

  // Event kinds
  localparam logic [3:0] K_TEXT = 4'd0;
  localparam logic [3:0] K_START = 4'd1;
  localparam logic [3:0] K_END = 4'd2;
  localparam logic [3:0] K_NAME = 4'd3;
  localparam logic [3:0] K_AOPEN = 4'd4;
  localparam logic [3:0] K_ANAME = 4'd5;
  localparam logic [3:0] K_AVAL = 4'd6;
  localparam logic [3:0] K_TCLOSE = 4'd7;
  localparam logic [3:0] K_COPEN = 4'd8;
  localparam logic [3:0] K_CCHAR = 4'd9;
  localparam logic [3:0] K_CCLOSE = 4'd10;
  localparam logic [3:0] K_EOF = 4'd11;
  localparam logic [3:0] K_ERR = 4'd12;

  // Parse errors
  localparam logic [4:0] E_NONE = 5'd0;
  localparam logic [4:0] E_NULL_DATA = 5'd1;
  localparam logic [4:0] E_UNK_NAMED = 5'd2;
  localparam logic [4:0] E_NO_DIGITS = 5'd3;
  localparam logic [4:0] E_NO_SEMI = 5'd4;
  localparam logic [4:0] E_NULL_REF = 5'd5;
  localparam logic [4:0] E_OUT_RANGE = 5'd6;
  localparam logic [4:0] E_SURR = 5'd7;
  localparam logic [4:0] E_NONCHAR = 5'd8;
  localparam logic [4:0] E_CTRL = 5'd9;
  localparam logic [4:0] E_QMARK = 5'd10;
  localparam logic [4:0] E_EOF_TNAME = 5'd11;
  localparam logic [4:0] E_BAD_TNAME = 5'd12;
  localparam logic [4:0] E_MISS_ETAG = 5'd13;
  localparam logic [4:0] E_NULL = 5'd14;
  localparam logic [4:0] E_EOF_TAG = 5'd15;
  localparam logic [4:0] E_SOLIDUS = 5'd16;
  localparam logic [4:0] E_EQ_ANAME = 5'd17;
  localparam logic [4:0] E_BAD_ANAME = 5'd18;
  localparam logic [4:0] E_MISS_AVAL = 5'd19;
  localparam logic [4:0] E_BAD_UQVAL = 5'd20;
  localparam logic [4:0] E_MISS_WS = 5'd21;
  localparam logic [4:0] E_BAD_COPEN = 5'd22;
  localparam logic [4:0] E_ABRUPT_C = 5'd23;
  localparam logic [4:0] E_EOF_COM = 5'd24;
  localparam logic [4:0] E_NESTED = 5'd25;
  localparam logic [4:0] E_BAD_CCLOSE = 5'd26;

  // Tokenizer states
  localparam logic [5:0] S_DATA = 6'd0;
  localparam logic [5:0] S_CREF = 6'd1;
  localparam logic [5:0] S_AMBIG = 6'd2;
  localparam logic [5:0] S_NREF = 6'd3;
  localparam logic [5:0] S_HEXS = 6'd4;
  localparam logic [5:0] S_DECS = 6'd5;
  localparam logic [5:0] S_HEX = 6'd6;
  localparam logic [5:0] S_DEC = 6'd7;
  localparam logic [5:0] S_TOPEN = 6'd8;
  localparam logic [5:0] S_ETOPEN = 6'd9;
  localparam logic [5:0] S_TNAME = 6'd10;
  localparam logic [5:0] S_SELFC = 6'd11;
  localparam logic [5:0] S_BAN = 6'd12;
  localparam logic [5:0] S_ANAME = 6'd13;
  localparam logic [5:0] S_AAN = 6'd14;
  localparam logic [5:0] S_BAV = 6'd15;
  localparam logic [5:0] S_AVDQ = 6'd16;
  localparam logic [5:0] S_AVSQ = 6'd17;
  localparam logic [5:0] S_AVUQ = 6'd18;
  localparam logic [5:0] S_AAVQ = 6'd19;
  localparam logic [5:0] S_MDO = 6'd20;
  localparam logic [5:0] S_MDOD = 6'd21;
  localparam logic [5:0] S_CSTART = 6'd22;
  localparam logic [5:0] S_CSD = 6'd23;
  localparam logic [5:0] S_COM = 6'd24;
  localparam logic [5:0] S_CLT = 6'd25;
  localparam logic [5:0] S_CLTB = 6'd26;
  localparam logic [5:0] S_CLTBD = 6'd27;
  localparam logic [5:0] S_CLTBDD = 6'd28;
  localparam logic [5:0] S_CED = 6'd29;
  localparam logic [5:0] S_CEND = 6'd30;
  localparam logic [5:0] S_CEB = 6'd31;
  localparam logic [5:0] S_BOGUS = 6'd32;
  localparam logic [5:0] S_NONE = 6'd63;

  // Reference prefix after "&#"
  localparam logic [1:0] P_NONE = 2'd0;
  localparam logic [1:0] P_LX = 2'd1;
  localparam logic [1:0] P_UX = 2'd2;

  localparam logic [20:0] MaxCp = 21'h10FFFF;
  localparam logic [20:0] SatCp = 21'h110000;
  localparam logic [20:0] Repl = 21'h00FFFD;

  typedef struct packed {
    logic [3:0]  kind;
    logic [20:0] ch;
    logic        sc;
    logic [4:0]  err;
  } ev_t;

  typedef struct packed {
    logic [2:0]        n;
    ev_t [MaxEv-1:0]   e;
  } ev_list_t;

  typedef struct packed {
    logic [5:0]  st;
    logic [5:0]  rs;
    logic [20:0] acc;
    logic [1:0]  pfx;
    logic        again;
    ev_list_t    l;
  } ctx_t;

  function automatic ev_list_t ev_put(ev_list_t l, logic [3:0] k, logic [20:0] c,
                                      logic sc, logic [4:0] err);
    ev_list_t r;
    r = l;
    if (l.n < 3'(MaxEv)) begin
      r.e[l.n] = '{kind: k, ch: c, sc: sc, err: err};
      r.n = l.n + 3'd1;
    end
    return r;
  endfunction

  function automatic logic is_c(logic [20:0] cp, logic eof, logic [7:0] a);
    return !eof && (cp == {13'd0, a});
  endfunction

  function automatic logic in_rng(logic [20:0] cp, logic eof, logic [7:0] lo,
                                  logic [7:0] hi);
    return !eof && (cp >= {13'd0, lo}) && (cp <= {13'd0, hi});
  endfunction

  function automatic logic is_ws(logic [20:0] cp, logic eof);
    return is_c(cp, eof, 8'h09) || is_c(cp, eof, 8'h0A) || is_c(cp, eof, 8'h0C) ||
           is_c(cp, eof, 8'h0D) || is_c(cp, eof, 8'h20);
  endfunction

  function automatic logic is_upper(logic [20:0] cp, logic eof);
    return in_rng(cp, eof, 8'h41, 8'h5A);
  endfunction

  function automatic logic is_digit(logic [20:0] cp, logic eof);
    return in_rng(cp, eof, 8'h30, 8'h39);
  endfunction

  function automatic logic is_alpha(logic [20:0] cp, logic eof);
    return is_upper(cp, eof) || in_rng(cp, eof, 8'h61, 8'h7A);
  endfunction

  function automatic logic is_hex(logic [20:0] cp, logic eof);
    return is_digit(cp, eof) || in_rng(cp, eof, 8'h41, 8'h46) ||
           in_rng(cp, eof, 8'h61, 8'h66);
  endfunction

  // Windows-1252 remap of C1 controls, zero where there is no entry
  function automatic logic [15:0] c1_map(logic [4:0] i);
    logic [15:0] r;
    unique case (i)
      5'd0:  r = 16'h20AC;
      5'd2:  r = 16'h201A;
      5'd3:  r = 16'h0192;
      5'd4:  r = 16'h201E;
      5'd5:  r = 16'h2026;
      5'd6:  r = 16'h2020;
      5'd7:  r = 16'h2021;
      5'd8:  r = 16'h02C6;
      5'd9:  r = 16'h2030;
      5'd10: r = 16'h0160;
      5'd11: r = 16'h2039;
      5'd12: r = 16'h0152;
      5'd14: r = 16'h017D;
      5'd17: r = 16'h2018;
      5'd18: r = 16'h2019;
      5'd19: r = 16'h201C;
      5'd20: r = 16'h201D;
      5'd21: r = 16'h2022;
      5'd22: r = 16'h2013;
      5'd23: r = 16'h2014;
      5'd24: r = 16'h02DC;
      5'd25: r = 16'h2122;
      5'd26: r = 16'h0161;
      5'd27: r = 16'h203A;
      5'd28: r = 16'h0153;
      5'd30: r = 16'h017E;
      5'd31: r = 16'h0178;
      default: r = 16'h0000;
    endcase
    return r;
  endfunction

  function automatic logic in_attr(logic [5:0] rs);
    return (rs == S_AVDQ) || (rs == S_AVSQ) || (rs == S_AVUQ);
  endfunction

  function automatic logic [5:0] back_st(logic [5:0] rs);
    return in_attr(rs) ? rs : S_DATA;
  endfunction

  function automatic ev_list_t refch(ev_list_t l, logic [5:0] rs, logic [20:0] c);
    return ev_put(l, in_attr(rs) ? K_AVAL : K_TEXT, c, 1'b0, E_NONE);
  endfunction

  function automatic ev_list_t perr(ev_list_t l, logic [4:0] e);
    return ev_put(l, K_ERR, 21'd0, 1'b0, e);
  endfunction

  // End of a numeric reference: checks, replacement, emitted character
  function automatic ev_list_t num_end(ev_list_t l, logic [5:0] rs, logic [20:0] acc);
    ev_list_t    r;
    logic [20:0] v;
    logic        ctl;
    logic [15:0] m;
    r = l;
    v = acc;
    ctl = (v <= 21'h1F) || ((v >= 21'h7F) && (v <= 21'h9F));
    m = c1_map(v[4:0]);
    if (v == 21'd0) begin
      r = perr(r, E_NULL_REF);
      v = Repl;
    end else if (v > MaxCp) begin
      r = perr(r, E_OUT_RANGE);
      v = Repl;
    end else if ((v >= 21'hD800) && (v <= 21'hDFFF)) begin
      r = perr(r, E_SURR);
      v = Repl;
    end else if (((v >= 21'hFDD0) && (v <= 21'hFDEF)) || (v[15:1] == 15'h7FFF)) begin
      r = perr(r, E_NONCHAR);
    end else if ((v == 21'h0D) || (ctl && !is_ws(v, 1'b0))) begin
      r = perr(r, E_CTRL);
      if ((v >= 21'h80) && (v <= 21'h9F) && (m != 16'd0)) v = {5'd0, m};
    end
    return refch(r, rs, v);
  endfunction

  function automatic logic [20:0] acc_push(logic [20:0] a, logic hex, logic [3:0] d);
    logic [25:0] t;
    t = hex ? {1'b0, a, 4'd0} : ({4'd0, a, 1'b0} + {2'd0, a, 3'd0});
    t = t + {22'd0, d};
    if (a > MaxCp || t > {5'd0, MaxCp}) return SatCp;
    return t[20:0];
  endfunction

  // One pass of the state machine over one character
  function automatic ctx_t fsm_step(ctx_t s, logic [20:0] cp, logic eof);
    ctx_t        r;
    logic [20:0] lc;
    logic [3:0]  hv;
    r = s;
    r.again = 1'b0;
    lc = cp + 21'd32;
    hv = is_digit(cp, eof) ? cp[3:0] : cp[3:0] + 4'd9;
    unique case (s.st)
      S_CREF: begin
        if (is_alpha(cp, eof) || is_digit(cp, eof)) begin
          r.l = refch(r.l, s.rs, 21'h26); r.st = S_AMBIG; r.again = 1'b1;
        end else if (is_c(cp, eof, 8'h23)) begin
          r.pfx = P_NONE; r.st = S_NREF;
        end else begin
          r.l = refch(r.l, s.rs, 21'h26); r.st = back_st(s.rs); r.again = 1'b1;
        end
      end
      S_AMBIG: begin
        if (is_alpha(cp, eof) || is_digit(cp, eof)) r.l = refch(r.l, s.rs, cp);
        else begin
          if (is_c(cp, eof, 8'h3B)) r.l = perr(r.l, E_UNK_NAMED);
          r.st = back_st(s.rs); r.again = 1'b1;
        end
      end
      S_NREF: begin
        r.acc = 21'd0;
        if (is_c(cp, eof, 8'h78)) begin
          r.pfx = P_LX; r.st = S_HEXS;
        end else if (is_c(cp, eof, 8'h58)) begin
          r.pfx = P_UX; r.st = S_HEXS;
        end else begin
          r.st = S_DECS; r.again = 1'b1;
        end
      end
      S_HEXS, S_DECS: begin
        if ((s.st == S_HEXS) ? is_hex(cp, eof) : is_digit(cp, eof)) begin
          r.st = (s.st == S_HEXS) ? S_HEX : S_DEC; r.again = 1'b1;
        end else begin
          r.l = perr(r.l, E_NO_DIGITS);
          r.l = refch(r.l, s.rs, 21'h26);
          r.l = refch(r.l, s.rs, 21'h23);
          if (s.pfx == P_LX) r.l = refch(r.l, s.rs, 21'h78);
          else if (s.pfx == P_UX) r.l = refch(r.l, s.rs, 21'h58);
          r.st = back_st(s.rs); r.again = 1'b1;
        end
      end
      S_HEX, S_DEC: begin
        if (s.st == S_HEX && is_hex(cp, eof)) r.acc = acc_push(s.acc, 1'b1, hv);
        else if (s.st == S_DEC && is_digit(cp, eof)) r.acc = acc_push(s.acc, 1'b0, cp[3:0]);
        else if (is_c(cp, eof, 8'h3B)) begin
          r.l = num_end(r.l, s.rs, s.acc); r.st = back_st(s.rs);
        end else begin
          r.l = perr(r.l, E_NO_SEMI);
          r.l = num_end(r.l, s.rs, s.acc);
          r.st = back_st(s.rs); r.again = 1'b1;
        end
      end
      S_TOPEN: begin
        if (is_c(cp, eof, 8'h21)) r.st = S_MDO;
        else if (is_c(cp, eof, 8'h2F)) r.st = S_ETOPEN;
        else if (is_alpha(cp, eof)) begin
          r.l = ev_put(r.l, K_START, 21'd0, 1'b0, E_NONE); r.st = S_TNAME; r.again = 1'b1;
        end else if (is_c(cp, eof, 8'h3F)) begin
          r.l = perr(r.l, E_QMARK);
          r.l = ev_put(r.l, K_COPEN, 21'd0, 1'b0, E_NONE);
          r.st = S_BOGUS; r.again = 1'b1;
        end else if (eof) begin
          r.l = perr(r.l, E_EOF_TNAME);
          r.l = ev_put(r.l, K_TEXT, 21'h3C, 1'b0, E_NONE);
          r.l = ev_put(r.l, K_EOF, 21'd0, 1'b0, E_NONE);
        end else begin
          r.l = perr(r.l, E_BAD_TNAME);
          r.l = ev_put(r.l, K_TEXT, 21'h3C, 1'b0, E_NONE);
          r.st = S_DATA; r.again = 1'b1;
        end
      end
      S_ETOPEN: begin
        if (is_alpha(cp, eof)) begin
          r.l = ev_put(r.l, K_END, 21'd0, 1'b0, E_NONE); r.st = S_TNAME; r.again = 1'b1;
        end else if (is_c(cp, eof, 8'h3E)) begin
          r.l = perr(r.l, E_MISS_ETAG); r.st = S_DATA;
        end else if (eof) begin
          r.l = perr(r.l, E_EOF_TNAME);
          r.l = ev_put(r.l, K_TEXT, 21'h3C, 1'b0, E_NONE);
          r.l = ev_put(r.l, K_TEXT, 21'h2F, 1'b0, E_NONE);
          r.l = ev_put(r.l, K_EOF, 21'd0, 1'b0, E_NONE);
        end else begin
          r.l = perr(r.l, E_BAD_TNAME);
          r.l = ev_put(r.l, K_COPEN, 21'd0, 1'b0, E_NONE);
          r.st = S_BOGUS; r.again = 1'b1;
        end
      end
      S_TNAME: begin
        if (is_ws(cp, eof)) r.st = S_BAN;
        else if (is_c(cp, eof, 8'h2F)) r.st = S_SELFC;
        else if (is_c(cp, eof, 8'h3E)) begin
          r.l = ev_put(r.l, K_TCLOSE, 21'd0, 1'b0, E_NONE); r.st = S_DATA;
        end else if (is_upper(cp, eof)) r.l = ev_put(r.l, K_NAME, lc, 1'b0, E_NONE);
        else if (is_c(cp, eof, 8'h00)) begin
          r.l = perr(r.l, E_NULL); r.l = ev_put(r.l, K_NAME, Repl, 1'b0, E_NONE);
        end else if (eof) begin
          r.l = perr(r.l, E_EOF_TAG); r.l = ev_put(r.l, K_EOF, 21'd0, 1'b0, E_NONE);
        end else r.l = ev_put(r.l, K_NAME, cp, 1'b0, E_NONE);
      end
      S_SELFC: begin
        if (is_c(cp, eof, 8'h3E)) begin
          r.l = ev_put(r.l, K_TCLOSE, 21'd0, 1'b1, E_NONE); r.st = S_DATA;
        end else if (eof) begin
          r.l = perr(r.l, E_EOF_TAG); r.l = ev_put(r.l, K_EOF, 21'd0, 1'b0, E_NONE);
        end else begin
          r.l = perr(r.l, E_SOLIDUS); r.st = S_BAN; r.again = 1'b1;
        end
      end
      S_BAN: begin
        if (is_ws(cp, eof)) r.st = S_BAN;
        else if (is_c(cp, eof, 8'h2F) || is_c(cp, eof, 8'h3E) || eof) begin
          r.st = S_AAN; r.again = 1'b1;
        end else if (is_c(cp, eof, 8'h3D)) begin
          r.l = perr(r.l, E_EQ_ANAME);
          r.l = ev_put(r.l, K_AOPEN, 21'd0, 1'b0, E_NONE);
          r.l = ev_put(r.l, K_ANAME, cp, 1'b0, E_NONE);
          r.st = S_ANAME;
        end else begin
          r.l = ev_put(r.l, K_AOPEN, 21'd0, 1'b0, E_NONE); r.st = S_ANAME; r.again = 1'b1;
        end
      end
      S_ANAME: begin
        if (is_ws(cp, eof) || is_c(cp, eof, 8'h2F) || is_c(cp, eof, 8'h3E) || eof) begin
          r.st = S_AAN; r.again = 1'b1;
        end else if (is_c(cp, eof, 8'h3D)) r.st = S_BAV;
        else if (is_upper(cp, eof)) r.l = ev_put(r.l, K_ANAME, lc, 1'b0, E_NONE);
        else if (is_c(cp, eof, 8'h00)) begin
          r.l = perr(r.l, E_NULL); r.l = ev_put(r.l, K_ANAME, Repl, 1'b0, E_NONE);
        end else begin
          if (is_c(cp, eof, 8'h22) || is_c(cp, eof, 8'h27) || is_c(cp, eof, 8'h3C))
            r.l = perr(r.l, E_BAD_ANAME);
          r.l = ev_put(r.l, K_ANAME, cp, 1'b0, E_NONE);
        end
      end
      S_AAN: begin
        if (is_ws(cp, eof)) r.st = S_AAN;
        else if (is_c(cp, eof, 8'h2F)) r.st = S_SELFC;
        else if (is_c(cp, eof, 8'h3D)) r.st = S_BAV;
        else if (is_c(cp, eof, 8'h3E)) begin
          r.l = ev_put(r.l, K_TCLOSE, 21'd0, 1'b0, E_NONE); r.st = S_DATA;
        end else if (eof) begin
          r.l = perr(r.l, E_EOF_TAG); r.l = ev_put(r.l, K_EOF, 21'd0, 1'b0, E_NONE);
        end else begin
          r.l = ev_put(r.l, K_AOPEN, 21'd0, 1'b0, E_NONE); r.st = S_ANAME; r.again = 1'b1;
        end
      end
      S_BAV: begin
        if (is_ws(cp, eof)) r.st = S_BAV;
        else if (is_c(cp, eof, 8'h22)) r.st = S_AVDQ;
        else if (is_c(cp, eof, 8'h27)) r.st = S_AVSQ;
        else if (is_c(cp, eof, 8'h3E)) begin
          r.l = perr(r.l, E_MISS_AVAL);
          r.l = ev_put(r.l, K_TCLOSE, 21'd0, 1'b0, E_NONE);
          r.st = S_DATA;
        end else begin
          r.st = S_AVUQ; r.again = 1'b1;
        end
      end
      S_AVDQ, S_AVSQ: begin
        if (is_c(cp, eof, (s.st == S_AVDQ) ? 8'h22 : 8'h27)) r.st = S_AAVQ;
        else if (is_c(cp, eof, 8'h26)) begin
          r.rs = s.st; r.st = S_CREF;
        end else if (is_c(cp, eof, 8'h00)) begin
          r.l = perr(r.l, E_NULL); r.l = ev_put(r.l, K_AVAL, Repl, 1'b0, E_NONE);
        end else if (eof) begin
          r.l = perr(r.l, E_EOF_TAG); r.l = ev_put(r.l, K_EOF, 21'd0, 1'b0, E_NONE);
        end else r.l = ev_put(r.l, K_AVAL, cp, 1'b0, E_NONE);
      end
      S_AVUQ: begin
        if (is_ws(cp, eof)) r.st = S_BAN;
        else if (is_c(cp, eof, 8'h26)) begin
          r.rs = S_AVUQ; r.st = S_CREF;
        end else if (is_c(cp, eof, 8'h3E)) begin
          r.l = ev_put(r.l, K_TCLOSE, 21'd0, 1'b0, E_NONE); r.st = S_DATA;
        end else if (is_c(cp, eof, 8'h00)) begin
          r.l = perr(r.l, E_NULL); r.l = ev_put(r.l, K_AVAL, Repl, 1'b0, E_NONE);
        end else if (is_c(cp, eof, 8'h22) || is_c(cp, eof, 8'h27) || is_c(cp, eof, 8'h3C) ||
                     is_c(cp, eof, 8'h3D) || is_c(cp, eof, 8'h60)) begin
          r.l = perr(r.l, E_BAD_UQVAL); r.l = ev_put(r.l, K_AVAL, cp, 1'b0, E_NONE);
        end else if (eof) begin
          r.l = perr(r.l, E_EOF_TAG); r.l = ev_put(r.l, K_EOF, 21'd0, 1'b0, E_NONE);
        end else r.l = ev_put(r.l, K_AVAL, cp, 1'b0, E_NONE);
      end
      S_AAVQ: begin
        if (is_ws(cp, eof)) r.st = S_BAN;
        else if (is_c(cp, eof, 8'h2F)) r.st = S_SELFC;
        else if (is_c(cp, eof, 8'h3E)) begin
          r.l = ev_put(r.l, K_TCLOSE, 21'd0, 1'b0, E_NONE); r.st = S_DATA;
        end else if (eof) begin
          r.l = perr(r.l, E_EOF_TAG); r.l = ev_put(r.l, K_EOF, 21'd0, 1'b0, E_NONE);
        end else begin
          r.l = perr(r.l, E_MISS_WS); r.st = S_BAN; r.again = 1'b1;
        end
      end
      S_MDO: begin
        if (is_c(cp, eof, 8'h2D)) r.st = S_MDOD;
        else begin
          r.l = perr(r.l, E_BAD_COPEN);
          r.l = ev_put(r.l, K_COPEN, 21'd0, 1'b0, E_NONE);
          r.st = S_BOGUS; r.again = 1'b1;
        end
      end
      S_MDOD: begin
        if (is_c(cp, eof, 8'h2D)) begin
          r.l = ev_put(r.l, K_COPEN, 21'd0, 1'b0, E_NONE); r.st = S_CSTART;
        end else begin
          r.l = perr(r.l, E_BAD_COPEN);
          r.l = ev_put(r.l, K_COPEN, 21'd0, 1'b0, E_NONE);
          r.l = ev_put(r.l, K_CCHAR, 21'h2D, 1'b0, E_NONE);
          r.st = S_BOGUS; r.again = 1'b1;
        end
      end
      S_CSTART: begin
        if (is_c(cp, eof, 8'h2D)) r.st = S_CSD;
        else if (is_c(cp, eof, 8'h3E)) begin
          r.l = perr(r.l, E_ABRUPT_C);
          r.l = ev_put(r.l, K_CCLOSE, 21'd0, 1'b0, E_NONE);
          r.st = S_DATA;
        end else begin
          r.st = S_COM; r.again = 1'b1;
        end
      end
      S_CSD: begin
        if (is_c(cp, eof, 8'h2D)) r.st = S_CEND;
        else if (is_c(cp, eof, 8'h3E)) begin
          r.l = perr(r.l, E_ABRUPT_C);
          r.l = ev_put(r.l, K_CCLOSE, 21'd0, 1'b0, E_NONE);
          r.st = S_DATA;
        end else if (eof) begin
          r.l = perr(r.l, E_EOF_COM);
          r.l = ev_put(r.l, K_CCLOSE, 21'd0, 1'b0, E_NONE);
          r.l = ev_put(r.l, K_EOF, 21'd0, 1'b0, E_NONE);
        end else begin
          r.l = ev_put(r.l, K_CCHAR, 21'h2D, 1'b0, E_NONE); r.st = S_COM; r.again = 1'b1;
        end
      end
      S_COM: begin
        if (is_c(cp, eof, 8'h3C)) begin
          r.l = ev_put(r.l, K_CCHAR, cp, 1'b0, E_NONE); r.st = S_CLT;
        end else if (is_c(cp, eof, 8'h2D)) r.st = S_CED;
        else if (is_c(cp, eof, 8'h00)) begin
          r.l = perr(r.l, E_NULL); r.l = ev_put(r.l, K_CCHAR, Repl, 1'b0, E_NONE);
        end else if (eof) begin
          r.l = perr(r.l, E_EOF_COM);
          r.l = ev_put(r.l, K_CCLOSE, 21'd0, 1'b0, E_NONE);
          r.l = ev_put(r.l, K_EOF, 21'd0, 1'b0, E_NONE);
        end else r.l = ev_put(r.l, K_CCHAR, cp, 1'b0, E_NONE);
      end
      S_CLT: begin
        if (is_c(cp, eof, 8'h21)) begin
          r.l = ev_put(r.l, K_CCHAR, cp, 1'b0, E_NONE); r.st = S_CLTB;
        end else if (is_c(cp, eof, 8'h3C)) r.l = ev_put(r.l, K_CCHAR, cp, 1'b0, E_NONE);
        else begin
          r.st = S_COM; r.again = 1'b1;
        end
      end
      S_CLTB: begin
        if (is_c(cp, eof, 8'h2D)) r.st = S_CLTBD;
        else begin
          r.st = S_COM; r.again = 1'b1;
        end
      end
      S_CLTBD: begin
        if (is_c(cp, eof, 8'h2D)) r.st = S_CLTBDD;
        else begin
          r.st = S_CED; r.again = 1'b1;
        end
      end
      S_CLTBDD: begin
        if (!is_c(cp, eof, 8'h3E) && !eof) r.l = perr(r.l, E_NESTED);
        r.st = S_CEND; r.again = 1'b1;
      end
      S_CED: begin
        if (is_c(cp, eof, 8'h2D)) r.st = S_CEND;
        else if (eof) begin
          r.l = perr(r.l, E_EOF_COM);
          r.l = ev_put(r.l, K_CCLOSE, 21'd0, 1'b0, E_NONE);
          r.l = ev_put(r.l, K_EOF, 21'd0, 1'b0, E_NONE);
        end else begin
          r.l = ev_put(r.l, K_CCHAR, 21'h2D, 1'b0, E_NONE); r.st = S_COM; r.again = 1'b1;
        end
      end
      S_CEND: begin
        if (is_c(cp, eof, 8'h3E)) begin
          r.l = ev_put(r.l, K_CCLOSE, 21'd0, 1'b0, E_NONE); r.st = S_DATA;
        end else if (is_c(cp, eof, 8'h21)) r.st = S_CEB;
        else if (is_c(cp, eof, 8'h2D)) r.l = ev_put(r.l, K_CCHAR, 21'h2D, 1'b0, E_NONE);
        else if (eof) begin
          r.l = perr(r.l, E_EOF_COM);
          r.l = ev_put(r.l, K_CCLOSE, 21'd0, 1'b0, E_NONE);
          r.l = ev_put(r.l, K_EOF, 21'd0, 1'b0, E_NONE);
        end else begin
          r.l = ev_put(r.l, K_CCHAR, 21'h2D, 1'b0, E_NONE);
          r.l = ev_put(r.l, K_CCHAR, 21'h2D, 1'b0, E_NONE);
          r.st = S_COM; r.again = 1'b1;
        end
      end
      S_CEB: begin
        if (is_c(cp, eof, 8'h3E)) begin
          r.l = perr(r.l, E_BAD_CCLOSE);
          r.l = ev_put(r.l, K_CCLOSE, 21'd0, 1'b0, E_NONE);
          r.st = S_DATA;
        end else if (eof) begin
          r.l = perr(r.l, E_EOF_COM);
          r.l = ev_put(r.l, K_CCLOSE, 21'd0, 1'b0, E_NONE);
          r.l = ev_put(r.l, K_EOF, 21'd0, 1'b0, E_NONE);
        end else begin
          r.l = ev_put(r.l, K_CCHAR, 21'h2D, 1'b0, E_NONE);
          r.l = ev_put(r.l, K_CCHAR, 21'h2D, 1'b0, E_NONE);
          r.l = ev_put(r.l, K_CCHAR, 21'h21, 1'b0, E_NONE);
          if (is_c(cp, eof, 8'h2D)) r.st = S_CED;
          else begin
            r.st = S_COM; r.again = 1'b1;
          end
        end
      end
      S_BOGUS: begin
        if (is_c(cp, eof, 8'h3E)) begin
          r.l = ev_put(r.l, K_CCLOSE, 21'd0, 1'b0, E_NONE); r.st = S_DATA;
        end else if (eof) begin
          r.l = ev_put(r.l, K_CCLOSE, 21'd0, 1'b0, E_NONE);
          r.l = ev_put(r.l, K_EOF, 21'd0, 1'b0, E_NONE);
        end else if (is_c(cp, eof, 8'h00)) begin
          r.l = perr(r.l, E_NULL); r.l = ev_put(r.l, K_CCHAR, Repl, 1'b0, E_NONE);
        end else r.l = ev_put(r.l, K_CCHAR, cp, 1'b0, E_NONE);
      end
      default: begin
        // data state, and any unused code falls back to it
        r.st = S_DATA;
        if (is_c(cp, eof, 8'h26)) begin
          r.rs = S_DATA; r.st = S_CREF;
        end else if (is_c(cp, eof, 8'h3C)) r.st = S_TOPEN;
        else if (is_c(cp, eof, 8'h00)) begin
          r.l = perr(r.l, E_NULL_DATA); r.l = ev_put(r.l, K_TEXT, 21'd0, 1'b0, E_NONE);
        end else if (eof) r.l = ev_put(r.l, K_EOF, 21'd0, 1'b0, E_NONE);
        else r.l = ev_put(r.l, K_TEXT, cp, 1'b0, E_NONE);
      end
    endcase
    return r;
  endfunction

endpackage

@@ src/hst_front.sv @@
// ----------------------------------------------------------------------------
// hst_front
// Accepts code points, runs the tokenizer state machine and hands the
// events of each character to the event queue as one entry.
// ----------------------------------------------------------------------------
module hst_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [20:0]         in_cp,
  input  logic                in_eof,
  input  logic                q_full,
  output logic                in_ready,
  output logic                push,
  output hst_pkg::ev_list_t   push_entry
);

  logic [5:0]     st;
  logic [5:0]     rs;
  logic [20:0]    acc;
  logic [1:0]     pfx;
  hst_pkg::ctx_t  ctx;
  logic           accept;

  assign in_ready = !q_full;
  assign accept = in_valid && in_ready;

  // reconsume chain: a character may pass through a few states
  always_comb begin
    ctx = '{st: st, rs: rs, acc: acc, pfx: pfx, again: 1'b1, l: '0};
    for (int i = 0; i < hst_pkg::MaxPasses; i++) begin
      if (ctx.again) ctx = hst_pkg::fsm_step(ctx, in_cp, in_eof);
    end
  end

  assign push = accept && (ctx.l.n != 3'd0);
  assign push_entry = ctx.l;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= hst_pkg::S_DATA;
      rs <= hst_pkg::S_NONE;
      acc <= '0;
      pfx <= hst_pkg::P_NONE;
    end else if (accept) begin
      st <= ctx.st;
      rs <= ctx.rs;
      acc <= ctx.acc;
      pfx <= ctx.pfx;
    end
  end

endmodule

@@ src/hst_fifo.sv @@
// ----------------------------------------------------------------------------
// hst_fifo
// Short queue of per-character event entries between front and back.
// ----------------------------------------------------------------------------
module hst_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  hst_pkg::ev_list_t   push_entry,
  input  logic                pop,
  output logic                full,
  output logic                empty,
  output hst_pkg::ev_list_t   head
);

  localparam int unsigned AW = $clog2(hst_pkg::FifoDepth);

  hst_pkg::ev_list_t        mem [hst_pkg::FifoDepth];
  logic [AW-1:0]            wr_ptr;
  logic [AW-1:0]            rd_ptr;
  logic [AW:0]              count;

  assign full = (count == (AW+1)'(hst_pkg::FifoDepth));
  assign empty = (count == '0);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

@@ src/hst_back.sv @@
// ----------------------------------------------------------------------------
// hst_back
// Walks the queue head entry one event at a time into the output register.
// ----------------------------------------------------------------------------
module hst_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                empty,
  input  hst_pkg::ev_list_t   head,
  output logic                pop,
  output logic                out_valid,
  output hst_pkg::ev_t        out_ev,
  output logic                out_last,
  input  logic                out_ready
);

  logic [2:0] idx;
  logic       load;
  logic       at_end;

  assign load = !empty && (!out_valid || out_ready);
  assign at_end = (idx == head.n - 3'd1);
  assign pop = load && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx <= at_end ? 3'd0 : idx + 3'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_ev <= head.e[idx];
      out_last <= at_end;
    end
  end

endmodule

@@ src/html_stream_tokenizer_top.sv @@
// ----------------------------------------------------------------------------
// html_stream_tokenizer_top
// Streaming HTML tokenizer: one code point in, zero to six events out.
// ----------------------------------------------------------------------------
// Channel  Dir  Transaction
// s_axis   in   one code point or end of file (tuser)
// m_axis   out  one event; tlast on the last event of a code point
//
// The front takes one code point per cycle while the 4-entry queue has room.
// The back sends one event per cycle while the sink is ready, so a code point
// with n events holds the output until all are sent; the queue absorbs bursts
// of multi-event characters. Events pass the queue, then the output register.
// Reset clears state to data. Output stalls back up through the queue to s_tready.
// ----------------------------------------------------------------------------
module html_stream_tokenizer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [20:0] code_point, zero pad
  input  logic        s_tuser,   // [0] is_eof
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [3:0] event_kind, [24:4] char_value,
                                 // [25] self_closing, [30:26] error_code, pad
  output logic        m_tlast
);

  hst_pkg::ev_list_t  push_entry;
  hst_pkg::ev_list_t  head;
  hst_pkg::ev_t       out_ev;
  logic               push;
  logic               pop;
  logic               full;
  logic               empty;

  hst_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_cp      (s_tdata[20:0]),
    .in_eof     (s_tuser),
    .q_full     (full),
    .in_ready   (s_tready),
    .push       (push),
    .push_entry (push_entry)
  );

  hst_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (full),
    .empty      (empty),
    .head       (head)
  );

  hst_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .head      (head),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ev    (out_ev),
    .out_last  (m_tlast),
    .out_ready (m_tready)
  );

  assign m_tdata = {1'b0, out_ev.err, out_ev.sc, out_ev.ch, out_ev.kind};

endmodule

@@ src/hst_checker.sv @@
// ----------------------------------------------------------------------------
// hst_checker
// Port-level checks on the tokenizer output stream.
// ----------------------------------------------------------------------------
module hst_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output transaction changed while stalled");

  a_rst_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_err_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[3:0] == hst_pkg::K_ERR) == (m_tdata[30:26] != hst_pkg::E_NONE)))
    else $error("error code does not match event kind");

  a_self_close: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[25] |-> m_tdata[3:0] == hst_pkg::K_TCLOSE)
    else $error("self-closing flag outside tag close");

  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3:0] == hst_pkg::K_EOF |-> m_tlast)
    else $error("end-of-file event not last of its transaction");

endmodule

bind html_stream_tokenizer_top hst_checker u_hst_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

@@ tb/sv/tb_html_stream_tokenizer_top.sv @@
// ----------------------------------------------------------------------------
// tb_html_stream_tokenizer_top
// Self-checking bench for the streaming HTML tokenizer. A behavioral model of
// the tokenizer predicts the events of each accepted code point; the monitor
// compares every output transaction with the oldest prediction. Traffic is
// directed markup corner cases, then random and malformed markup with noise,
// under several phases of source idling and sink stalling.
// ----------------------------------------------------------------------------
module tb_html_stream_tokenizer_top;

  typedef struct packed {
    logic [3:0]  kind;
    logic [20:0] ch;
    logic        sc;
    logic [4:0]  err;
    logic        last;
  } tok_ev_t;

  typedef struct packed {
    logic [20:0] cp;
    logic        eof;
    logic [1:0]  phase;
  } char_item_t;

  localparam int unsigned Limit = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tlast;

  html_stream_tokenizer_top dut (.*);

  always #5 clk = ~clk;

  char_item_t pending_chars[$];
  tok_ev_t    expected_events[$];
  int unsigned errors = 0;
  int unsigned chars_sent = 0;
  int unsigned events_seen = 0;
  int unsigned cycles = 0;
  logic [1:0]  phase = 2'd0;
  logic        hold_source = 1'b0;

  // predictor state
  logic [5:0]  tk_state = hst_pkg::S_DATA;
  logic [5:0]  tk_ret = hst_pkg::S_NONE;
  logic [20:0] tk_acc = '0;
  logic [1:0]  tk_pfx = hst_pkg::P_NONE;
  tok_ev_t     step_evs[$];

  function automatic bit is_space(logic [31:0] c);
    return c == 32'h09 || c == 32'h0A || c == 32'h0C || c == 32'h0D || c == 32'h20;
  endfunction
  function automatic bit is_up(logic [31:0] c);
    return c >= 32'h41 && c <= 32'h5A;
  endfunction
  function automatic bit is_dig(logic [31:0] c);
    return c >= 32'h30 && c <= 32'h39;
  endfunction
  function automatic bit is_let(logic [31:0] c);
    return is_up(c) || (c >= 32'h61 && c <= 32'h7A);
  endfunction
  function automatic bit is_hx(logic [31:0] c);
    return is_dig(c) || (c >= 32'h41 && c <= 32'h46) || (c >= 32'h61 && c <= 32'h66);
  endfunction

  task automatic emit(logic [3:0] k, logic [31:0] c, logic sc, logic [4:0] e);
    tok_ev_t ev;
    if (step_evs.size() < hst_pkg::MaxEv) begin
      ev = '{kind: k, ch: c[20:0], sc: sc, err: e, last: 1'b0};
      step_evs.push_back(ev);
    end
  endtask

  task automatic emit_err(logic [4:0] e);
    emit(hst_pkg::K_ERR, 0, 1'b0, e);
  endtask

  task automatic emit_ev(logic [3:0] k, logic [31:0] c);
    emit(k, c, 1'b0, hst_pkg::E_NONE);
  endtask

  function automatic bit ret_in_value();
    return tk_ret == hst_pkg::S_AVDQ || tk_ret == hst_pkg::S_AVSQ ||
           tk_ret == hst_pkg::S_AVUQ;
  endfunction

  function automatic logic [5:0] ret_target();
    return ret_in_value() ? tk_ret : hst_pkg::S_DATA;
  endfunction

  task automatic emit_ref(logic [31:0] c);
    emit_ev(ret_in_value() ? hst_pkg::K_AVAL : hst_pkg::K_TEXT, c);
  endtask

  function automatic logic [15:0] win1252(int i);
    logic [15:0] tbl [32] = '{16'h20AC, 0, 16'h201A, 16'h0192, 16'h201E, 16'h2026,
      16'h2020, 16'h2021, 16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 0,
      16'h017D, 0, 0, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013,
      16'h2014, 16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 0, 16'h017E,
      16'h0178};
    return tbl[i];
  endfunction

  task automatic finish_numeric();
    logic [31:0] v;
    v = tk_acc;
    if (v == 0) begin emit_err(hst_pkg::E_NULL_REF); v = 32'hFFFD; end
    else if (v > 32'h10FFFF) begin emit_err(hst_pkg::E_OUT_RANGE); v = 32'hFFFD; end
    else if (v >= 32'hD800 && v <= 32'hDFFF) begin emit_err(hst_pkg::E_SURR); v = 32'hFFFD; end
    else if ((v >= 32'hFDD0 && v <= 32'hFDEF) || (v & 32'hFFFE) == 32'hFFFE)
      emit_err(hst_pkg::E_NONCHAR);
    else if (v == 32'h0D || ((v <= 32'h1F || (v >= 32'h7F && v <= 32'h9F)) &&
             !is_space(v))) begin
      emit_err(hst_pkg::E_CTRL);
      if (v >= 32'h80 && v <= 32'h9F && win1252(v - 32'h80) != 0)
        v = win1252(v - 32'h80);
    end
    emit_ref(v);
  endtask

  task automatic accumulate(int base, logic [31:0] d);
    logic [31:0] a;
    a = tk_acc;
    if (a > 32'h10FFFF) a = 32'h110000;
    else begin
      a = a * base + d;
      if (a > 32'h10FFFF) a = 32'h110000;
    end
    tk_acc = a[20:0];
  endtask

  // Works out the events of one code point and queues them
  task automatic predict_events(logic [20:0] cp, logic eof);
    logic [31:0] c;
    bit          again;
    bit          iseof;
    int          passes;
    c = eof ? 32'hFFFF_FFFF : {11'd0, cp};
    iseof = eof;
    passes = 0;
    step_evs.delete();
    do begin
      again = 0;
      case (tk_state)
        hst_pkg::S_CREF:
          if (is_let(c) || is_dig(c)) begin
            emit_ref(32'h26); tk_state = hst_pkg::S_AMBIG; again = 1;
          end else if (c == 32'h23) begin
            tk_pfx = hst_pkg::P_NONE; tk_state = hst_pkg::S_NREF;
          end else begin
            emit_ref(32'h26); tk_state = ret_target(); again = 1;
          end
        hst_pkg::S_AMBIG:
          if (is_let(c) || is_dig(c)) emit_ref(c);
          else begin
            if (c == 32'h3B) emit_err(hst_pkg::E_UNK_NAMED);
            tk_state = ret_target(); again = 1;
          end
        hst_pkg::S_NREF: begin
          tk_acc = 0;
          if (c == 32'h78) begin tk_pfx = hst_pkg::P_LX; tk_state = hst_pkg::S_HEXS; end
          else if (c == 32'h58) begin tk_pfx = hst_pkg::P_UX; tk_state = hst_pkg::S_HEXS; end
          else begin tk_state = hst_pkg::S_DECS; again = 1; end
        end
        hst_pkg::S_HEXS, hst_pkg::S_DECS:
          if (tk_state == hst_pkg::S_HEXS ? is_hx(c) : is_dig(c)) begin
            tk_state = (tk_state == hst_pkg::S_HEXS) ? hst_pkg::S_HEX : hst_pkg::S_DEC;
            again = 1;
          end else begin
            emit_err(hst_pkg::E_NO_DIGITS);
            emit_ref(32'h26); emit_ref(32'h23);
            if (tk_pfx == hst_pkg::P_LX) emit_ref(32'h78);
            else if (tk_pfx == hst_pkg::P_UX) emit_ref(32'h58);
            tk_state = ret_target(); again = 1;
          end
        hst_pkg::S_HEX, hst_pkg::S_DEC:
          if (tk_state == hst_pkg::S_HEX && is_hx(c))
            accumulate(16, is_dig(c) ? c - 32'h30 : (c | 32'h20) - 32'h61 + 10);
          else if (tk_state == hst_pkg::S_DEC && is_dig(c)) accumulate(10, c - 32'h30);
          else if (c == 32'h3B) begin finish_numeric(); tk_state = ret_target(); end
          else begin
            emit_err(hst_pkg::E_NO_SEMI); finish_numeric();
            tk_state = ret_target(); again = 1;
          end
        hst_pkg::S_TOPEN:
          if (c == 32'h21) tk_state = hst_pkg::S_MDO;
          else if (c == 32'h2F) tk_state = hst_pkg::S_ETOPEN;
          else if (is_let(c)) begin
            emit_ev(hst_pkg::K_START, 0); tk_state = hst_pkg::S_TNAME; again = 1;
          end else if (c == 32'h3F) begin
            emit_err(hst_pkg::E_QMARK); emit_ev(hst_pkg::K_COPEN, 0);
            tk_state = hst_pkg::S_BOGUS; again = 1;
          end else if (iseof) begin
            emit_err(hst_pkg::E_EOF_TNAME); emit_ev(hst_pkg::K_TEXT, 32'h3C);
            emit_ev(hst_pkg::K_EOF, 0);
          end else begin
            emit_err(hst_pkg::E_BAD_TNAME); emit_ev(hst_pkg::K_TEXT, 32'h3C);
            tk_state = hst_pkg::S_DATA; again = 1;
          end
        hst_pkg::S_ETOPEN:
          if (is_let(c)) begin
            emit_ev(hst_pkg::K_END, 0); tk_state = hst_pkg::S_TNAME; again = 1;
          end else if (c == 32'h3E) begin
            emit_err(hst_pkg::E_MISS_ETAG); tk_state = hst_pkg::S_DATA;
          end else if (iseof) begin
            emit_err(hst_pkg::E_EOF_TNAME); emit_ev(hst_pkg::K_TEXT, 32'h3C);
            emit_ev(hst_pkg::K_TEXT, 32'h2F); emit_ev(hst_pkg::K_EOF, 0);
          end else begin
            emit_err(hst_pkg::E_BAD_TNAME); emit_ev(hst_pkg::K_COPEN, 0);
            tk_state = hst_pkg::S_BOGUS; again = 1;
          end
        hst_pkg::S_TNAME:
          if (is_space(c)) tk_state = hst_pkg::S_BAN;
          else if (c == 32'h2F) tk_state = hst_pkg::S_SELFC;
          else if (c == 32'h3E) begin
            emit_ev(hst_pkg::K_TCLOSE, 0); tk_state = hst_pkg::S_DATA;
          end else if (is_up(c)) emit_ev(hst_pkg::K_NAME, c + 32);
          else if (c == 0) begin
            emit_err(hst_pkg::E_NULL); emit_ev(hst_pkg::K_NAME, 32'hFFFD);
          end else if (iseof) begin
            emit_err(hst_pkg::E_EOF_TAG); emit_ev(hst_pkg::K_EOF, 0);
          end else emit_ev(hst_pkg::K_NAME, c);
        hst_pkg::S_SELFC:
          if (c == 32'h3E) begin
            emit(hst_pkg::K_TCLOSE, 0, 1'b1, hst_pkg::E_NONE); tk_state = hst_pkg::S_DATA;
          end else if (iseof) begin
            emit_err(hst_pkg::E_EOF_TAG); emit_ev(hst_pkg::K_EOF, 0);
          end else begin
            emit_err(hst_pkg::E_SOLIDUS); tk_state = hst_pkg::S_BAN; again = 1;
          end
        hst_pkg::S_BAN:
          if (is_space(c)) tk_state = hst_pkg::S_BAN;
          else if (c == 32'h2F || c == 32'h3E || iseof) begin
            tk_state = hst_pkg::S_AAN; again = 1;
          end else if (c == 32'h3D) begin
            emit_err(hst_pkg::E_EQ_ANAME); emit_ev(hst_pkg::K_AOPEN, 0);
            emit_ev(hst_pkg::K_ANAME, c);
            tk_state = hst_pkg::S_ANAME;
          end else begin
            emit_ev(hst_pkg::K_AOPEN, 0); tk_state = hst_pkg::S_ANAME; again = 1;
          end
        hst_pkg::S_ANAME:
          if (is_space(c) || c == 32'h2F || c == 32'h3E || iseof) begin
            tk_state = hst_pkg::S_AAN; again = 1;
          end else if (c == 32'h3D) tk_state = hst_pkg::S_BAV;
          else if (is_up(c)) emit_ev(hst_pkg::K_ANAME, c + 32);
          else if (c == 0) begin
            emit_err(hst_pkg::E_NULL); emit_ev(hst_pkg::K_ANAME, 32'hFFFD);
          end else begin
            if (c == 32'h22 || c == 32'h27 || c == 32'h3C) emit_err(hst_pkg::E_BAD_ANAME);
            emit_ev(hst_pkg::K_ANAME, c);
          end
        hst_pkg::S_AAN:
          if (is_space(c)) tk_state = hst_pkg::S_AAN;
          else if (c == 32'h2F) tk_state = hst_pkg::S_SELFC;
          else if (c == 32'h3D) tk_state = hst_pkg::S_BAV;
          else if (c == 32'h3E) begin
            emit_ev(hst_pkg::K_TCLOSE, 0); tk_state = hst_pkg::S_DATA;
          end else if (iseof) begin
            emit_err(hst_pkg::E_EOF_TAG); emit_ev(hst_pkg::K_EOF, 0);
          end else begin
            emit_ev(hst_pkg::K_AOPEN, 0); tk_state = hst_pkg::S_ANAME; again = 1;
          end
        hst_pkg::S_BAV:
          if (is_space(c)) tk_state = hst_pkg::S_BAV;
          else if (c == 32'h22) tk_state = hst_pkg::S_AVDQ;
          else if (c == 32'h27) tk_state = hst_pkg::S_AVSQ;
          else if (c == 32'h3E) begin
            emit_err(hst_pkg::E_MISS_AVAL); emit_ev(hst_pkg::K_TCLOSE, 0);
            tk_state = hst_pkg::S_DATA;
          end else begin tk_state = hst_pkg::S_AVUQ; again = 1; end
        hst_pkg::S_AVDQ, hst_pkg::S_AVSQ:
          if (c == (tk_state == hst_pkg::S_AVDQ ? 32'h22 : 32'h27)) tk_state = hst_pkg::S_AAVQ;
          else if (c == 32'h26) begin tk_ret = tk_state; tk_state = hst_pkg::S_CREF; end
          else if (c == 0) begin
            emit_err(hst_pkg::E_NULL); emit_ev(hst_pkg::K_AVAL, 32'hFFFD);
          end else if (iseof) begin
            emit_err(hst_pkg::E_EOF_TAG); emit_ev(hst_pkg::K_EOF, 0);
          end else emit_ev(hst_pkg::K_AVAL, c);
        hst_pkg::S_AVUQ:
          if (is_space(c)) tk_state = hst_pkg::S_BAN;
          else if (c == 32'h26) begin
            tk_ret = hst_pkg::S_AVUQ; tk_state = hst_pkg::S_CREF;
          end else if (c == 32'h3E) begin
            emit_ev(hst_pkg::K_TCLOSE, 0); tk_state = hst_pkg::S_DATA;
          end else if (c == 0) begin
            emit_err(hst_pkg::E_NULL); emit_ev(hst_pkg::K_AVAL, 32'hFFFD);
          end else if (c == 32'h22 || c == 32'h27 || c == 32'h3C || c == 32'h3D ||
                       c == 32'h60) begin
            emit_err(hst_pkg::E_BAD_UQVAL); emit_ev(hst_pkg::K_AVAL, c);
          end else if (iseof) begin
            emit_err(hst_pkg::E_EOF_TAG); emit_ev(hst_pkg::K_EOF, 0);
          end else emit_ev(hst_pkg::K_AVAL, c);
        hst_pkg::S_AAVQ:
          if (is_space(c)) tk_state = hst_pkg::S_BAN;
          else if (c == 32'h2F) tk_state = hst_pkg::S_SELFC;
          else if (c == 32'h3E) begin
            emit_ev(hst_pkg::K_TCLOSE, 0); tk_state = hst_pkg::S_DATA;
          end else if (iseof) begin
            emit_err(hst_pkg::E_EOF_TAG); emit_ev(hst_pkg::K_EOF, 0);
          end else begin
            emit_err(hst_pkg::E_MISS_WS); tk_state = hst_pkg::S_BAN; again = 1;
          end
        hst_pkg::S_MDO:
          if (c == 32'h2D) tk_state = hst_pkg::S_MDOD;
          else begin
            emit_err(hst_pkg::E_BAD_COPEN); emit_ev(hst_pkg::K_COPEN, 0);
            tk_state = hst_pkg::S_BOGUS; again = 1;
          end
        hst_pkg::S_MDOD:
          if (c == 32'h2D) begin
            emit_ev(hst_pkg::K_COPEN, 0); tk_state = hst_pkg::S_CSTART;
          end else begin
            emit_err(hst_pkg::E_BAD_COPEN); emit_ev(hst_pkg::K_COPEN, 0);
            emit_ev(hst_pkg::K_CCHAR, 32'h2D);
            tk_state = hst_pkg::S_BOGUS; again = 1;
          end
        hst_pkg::S_CSTART:
          if (c == 32'h2D) tk_state = hst_pkg::S_CSD;
          else if (c == 32'h3E) begin
            emit_err(hst_pkg::E_ABRUPT_C); emit_ev(hst_pkg::K_CCLOSE, 0);
            tk_state = hst_pkg::S_DATA;
          end else begin tk_state = hst_pkg::S_COM; again = 1; end
        hst_pkg::S_CSD:
          if (c == 32'h2D) tk_state = hst_pkg::S_CEND;
          else if (c == 32'h3E) begin
            emit_err(hst_pkg::E_ABRUPT_C); emit_ev(hst_pkg::K_CCLOSE, 0);
            tk_state = hst_pkg::S_DATA;
          end else if (iseof) begin
            emit_err(hst_pkg::E_EOF_COM); emit_ev(hst_pkg::K_CCLOSE, 0);
            emit_ev(hst_pkg::K_EOF, 0);
          end else begin
            emit_ev(hst_pkg::K_CCHAR, 32'h2D); tk_state = hst_pkg::S_COM; again = 1;
          end
        hst_pkg::S_COM:
          if (c == 32'h3C) begin
            emit_ev(hst_pkg::K_CCHAR, c); tk_state = hst_pkg::S_CLT;
          end else if (c == 32'h2D) tk_state = hst_pkg::S_CED;
          else if (c == 0) begin
            emit_err(hst_pkg::E_NULL); emit_ev(hst_pkg::K_CCHAR, 32'hFFFD);
          end else if (iseof) begin
            emit_err(hst_pkg::E_EOF_COM); emit_ev(hst_pkg::K_CCLOSE, 0);
            emit_ev(hst_pkg::K_EOF, 0);
          end else emit_ev(hst_pkg::K_CCHAR, c);
        hst_pkg::S_CLT:
          if (c == 32'h21) begin
            emit_ev(hst_pkg::K_CCHAR, c); tk_state = hst_pkg::S_CLTB;
          end else if (c == 32'h3C) emit_ev(hst_pkg::K_CCHAR, c);
          else begin tk_state = hst_pkg::S_COM; again = 1; end
        hst_pkg::S_CLTB:
          if (c == 32'h2D) tk_state = hst_pkg::S_CLTBD;
          else begin tk_state = hst_pkg::S_COM; again = 1; end
        hst_pkg::S_CLTBD:
          if (c == 32'h2D) tk_state = hst_pkg::S_CLTBDD;
          else begin tk_state = hst_pkg::S_CED; again = 1; end
        hst_pkg::S_CLTBDD: begin
          if (c != 32'h3E && !iseof) emit_err(hst_pkg::E_NESTED);
          tk_state = hst_pkg::S_CEND; again = 1;
        end
        hst_pkg::S_CED:
          if (c == 32'h2D) tk_state = hst_pkg::S_CEND;
          else if (iseof) begin
            emit_err(hst_pkg::E_EOF_COM); emit_ev(hst_pkg::K_CCLOSE, 0);
            emit_ev(hst_pkg::K_EOF, 0);
          end else begin
            emit_ev(hst_pkg::K_CCHAR, 32'h2D); tk_state = hst_pkg::S_COM; again = 1;
          end
        hst_pkg::S_CEND:
          if (c == 32'h3E) begin
            emit_ev(hst_pkg::K_CCLOSE, 0); tk_state = hst_pkg::S_DATA;
          end else if (c == 32'h21) tk_state = hst_pkg::S_CEB;
          else if (c == 32'h2D) emit_ev(hst_pkg::K_CCHAR, 32'h2D);
          else if (iseof) begin
            emit_err(hst_pkg::E_EOF_COM); emit_ev(hst_pkg::K_CCLOSE, 0);
            emit_ev(hst_pkg::K_EOF, 0);
          end else begin
            emit_ev(hst_pkg::K_CCHAR, 32'h2D); emit_ev(hst_pkg::K_CCHAR, 32'h2D);
            tk_state = hst_pkg::S_COM; again = 1;
          end
        hst_pkg::S_CEB:
          if (c == 32'h3E) begin
            emit_err(hst_pkg::E_BAD_CCLOSE); emit_ev(hst_pkg::K_CCLOSE, 0);
            tk_state = hst_pkg::S_DATA;
          end else if (iseof) begin
            emit_err(hst_pkg::E_EOF_COM); emit_ev(hst_pkg::K_CCLOSE, 0);
            emit_ev(hst_pkg::K_EOF, 0);
          end else begin
            emit_ev(hst_pkg::K_CCHAR, 32'h2D); emit_ev(hst_pkg::K_CCHAR, 32'h2D);
            emit_ev(hst_pkg::K_CCHAR, 32'h21);
            if (c == 32'h2D) tk_state = hst_pkg::S_CED;
            else begin tk_state = hst_pkg::S_COM; again = 1; end
          end
        hst_pkg::S_BOGUS:
          if (c == 32'h3E) begin
            emit_ev(hst_pkg::K_CCLOSE, 0); tk_state = hst_pkg::S_DATA;
          end else if (iseof) begin
            emit_ev(hst_pkg::K_CCLOSE, 0); emit_ev(hst_pkg::K_EOF, 0);
          end else if (c == 0) begin
            emit_err(hst_pkg::E_NULL); emit_ev(hst_pkg::K_CCHAR, 32'hFFFD);
          end else emit_ev(hst_pkg::K_CCHAR, c);
        default: begin
          tk_state = hst_pkg::S_DATA;
          if (c == 32'h26) begin tk_ret = hst_pkg::S_DATA; tk_state = hst_pkg::S_CREF; end
          else if (c == 32'h3C) tk_state = hst_pkg::S_TOPEN;
          else if (c == 0) begin
            emit_err(hst_pkg::E_NULL_DATA); emit_ev(hst_pkg::K_TEXT, 0);
          end else if (iseof) emit_ev(hst_pkg::K_EOF, 0);
          else emit_ev(hst_pkg::K_TEXT, c);
        end
      endcase
      passes++;
    end while (again && passes < 16);
    if (step_evs.size() > 0) step_evs[step_evs.size() - 1].last = 1'b1;
    foreach (step_evs[i]) expected_events.push_back(step_evs[i]);
  endtask

  // stimulus helpers
  task automatic add_cp(logic [20:0] cp, logic [1:0] ph);
    char_item_t it;
    it = '{cp: cp, eof: 1'b0, phase: ph};
    pending_chars.push_back(it);
  endtask

  task automatic add_str(string s, logic [1:0] ph);
    foreach (s[i]) add_cp({13'd0, s[i]}, ph);
  endtask

  task automatic add_eof(logic [1:0] ph);
    char_item_t it;
    it = '{cp: 21'($urandom), eof: 1'b1, phase: ph};
    pending_chars.push_back(it);
  endtask

  function automatic string pick(string a, string b);
    return ($urandom_range(0, 1) != 0) ? a : b;
  endfunction

  function automatic logic [20:0] rand_cp();
    case ($urandom_range(0, 5))
      0: return 21'($urandom_range(0, 127));
      1: return 21'($urandom_range(0, 21'h1FFFFF));
      2: return 21'($urandom_range(21'h80, 21'h10FFFF));
      3: return ($urandom_range(0, 1) != 0) ? 21'h10FFFF : 21'h1FFFFF;
      default: return 21'($urandom_range(32'h61, 32'h7A));
    endcase
  endfunction

  function automatic string rand_word(int n);
    string w;
    w = "";
    for (int i = 0; i < n; i++)
      w = {w, string'(byte'($urandom_range(0, 3) == 0 ? $urandom_range(65, 90)
                                                    : $urandom_range(97, 122)))};
    return w;
  endfunction

  function automatic string rand_ref();
    case ($urandom_range(0, 6))
      0: return $sformatf("&#%0d;", $urandom_range(0, 200));
      1: return $sformatf("&#x%0h;", $urandom_range(0, 32'h11FFFF));
      2: return $sformatf("&#X%0H", $urandom_range(32'hD7FF, 32'hE000));
      3: return "&amp;";
      4: return "&#99999999;";
      5: return $sformatf("&#x%0h;", $urandom_range(32'h7F, 32'h9F));
      default: return "&#;";
    endcase
  endfunction

  task automatic add_random_chunk(logic [1:0] ph);
    string s;
    case ($urandom_range(0, 9))
      0, 1: s = {"<", rand_word($urandom_range(1, 4)), " ", rand_word(2), "=\"",
                 rand_word(2), rand_ref(), "\" ", rand_word(1), "='v'",
                 pick("/>", ">")};
      2: s = {"<", rand_word(2), " a=", rand_word(2), rand_ref(), ">"};
      3: s = {"</", rand_word($urandom_range(1, 3)), ">"};
      4: s = {"<!--", rand_word(2), pick("<!--x", "-x--"), pick("-->", "--!>")};
      5: s = {"text", rand_ref(), " "};
      6: s = {"<?", rand_word(2), ">"};
      default: s = "";
    endcase
    add_str(s, ph);
    if (s.len() == 0)
      repeat ($urandom_range(1, 4)) add_cp(rand_cp(), ph);
  endtask

  // source
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        predict_events(s_tdata[20:0], s_tuser);
        chars_sent++;
      end
      if (pending_chars.size() > 0 && !hold_source &&
          !((pending_chars[0].phase == 2'd1 || pending_chars[0].phase == 2'd3) &&
            $urandom_range(0, 99) < (pending_chars[0].phase == 2'd3 ? 23 : 80))) begin
        char_item_t it;
        it = pending_chars.pop_front();
        phase <= it.phase;
        s_tvalid <= 1'b1;
        s_tdata <= {3'd0, it.cp};
        s_tuser <= it.eof;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // sink and checker
  always @(posedge clk) begin
    tok_ev_t got;
    tok_ev_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = '{kind: m_tdata[3:0], ch: m_tdata[24:4], sc: m_tdata[25],
                err: m_tdata[30:26], last: m_tlast};
        events_seen++;
        if (expected_events.size() == 0) begin
          errors++;
          $display("%0t unexpected event: expected none, actual %h", $time, got);
        end else begin
          want = expected_events.pop_front();
          if (got !== want || m_tdata[31] !== 1'b0) begin
            errors++;
            $display("%0t event mismatch: kind %0d/%0d ch %h/%h sc %0d/%0d err %0d/%0d last %0d/%0d",
                     $time, want.kind, got.kind, want.ch, got.ch, want.sc, got.sc,
                     want.err, got.err, want.last, got.last);
          end
        end
      end
      m_tready <= (phase == 2'd2) ? ($urandom_range(0, 99) >= 80) :
                  (phase == 2'd3) ? ($urandom_range(0, 99) >= 23) : 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > Limit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    string nasty [] = '{"a<b>", "<A HREF=x/>", "</>", "</9", "<9", "<?pi>",
      "&#0;&#x110000;&#xD800;&#xFFFE;&#13;&#x80;&#x81;&#9;", "&#x;&#X;&#;&zz;",
      "<a b='1'c=\"2&#65\" d=`e =f>", "<x /y>", "<!x><!-x>", "<!-->", "<!--->",
      "<!--a<!--b--!c--!>", "<!--a--b---->", "<p q=\"&lt;\">"};
    int k;
    k = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // directed corners, spread over the idling phases
    foreach (nasty[i]) add_str(nasty[i], 2'(i % 4));
    add_cp(21'd0, 2'd0);
    add_cp(21'h1FFFFF, 2'd0);
    add_str("<t", 2'd0); add_cp(21'd0, 2'd0);
    add_str(" n", 2'd0); add_cp(21'd0, 2'd0);
    add_str("=\"", 2'd0); add_cp(21'd0, 2'd0); add_str("\">", 2'd0);
    add_str("<!--", 2'd0); add_cp(21'd0, 2'd0); add_eof(2'd0);
    add_str("-->", 2'd0);
    add_str("<", 2'd0); add_eof(2'd0); add_str("</", 2'd0); add_eof(2'd0);
    add_str("<z k=", 2'd0); add_eof(2'd0); add_str(">", 2'd0);
    add_str("<?", 2'd0); add_eof(2'd0); add_str(">", 2'd0);
    // a little random markup, rotating through the idling phases
    while (pending_chars.size() < 240) begin
      add_random_chunk(2'(k % 4));
      k++;
    end
    add_eof(2'd0);
    // drain once part way through
    while (pending_chars.size() > 120) @(posedge clk);
    hold_source <= 1'b1;
    while (s_tvalid || expected_events.size() > 0) @(posedge clk);
    hold_source <= 1'b0;
    while (pending_chars.size() > 0 || s_tvalid) @(posedge clk);
    while (expected_events.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d code points, checked %0d events across four handshake phases.",
             chars_sent, events_seen);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
